@@ rtl/n2a_pkg.sv @@
// Shared types, constants and the digit-to-character function for the
// number-to-ASCII formatter. No dependencies.
`timescale 1ns / 1ps

package n2a_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);

  localparam logic [CHAR_W-1:0]  DIGIT_BASE = 8'h30;
  localparam logic [CHAR_W-1:0]  ALPHA_BASE = 8'd97;
  localparam logic [CHAR_W-1:0]  CHAR_X     = 8'h78;
  localparam logic [DIGIT_W-1:0] RADIX_DEC  = 4'd10;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        PROD_W      = 2 * VALUE_W;
  localparam int unsigned        QUOT_W      = PROD_W - RECIP_SHIFT;

  // One conversion job as it travels from the front end to the engine
  typedef struct packed {
    logic               hex;
    logic [VALUE_W-1:0] value;
  } job_t;

  // Map one digit (0..15) to its lower-case ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < RADIX_DEC) begin
      return DIGIT_BASE + d_ext;
    end
    return ALPHA_BASE + d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, RADIX_DEC};
  endfunction

endpackage

@@ rtl/n2a_front.sv @@
// Front end: takes input beats, decodes the radix select and holds the job
// in one stage register for the queue. Depends on n2a_pkg.
`timescale 1ns / 1ps

module n2a_front import n2a_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic               in_tuser,   // [0] action (1 = hex with 0x prefix)
  output logic               push_valid,
  input  logic               push_ready,
  output job_t               push_job
);

  logic st_valid_r, st_valid_nxt;
  job_t st_job_r;
  logic in_take;

  // Accept a beat when the stage is empty or drains this cycle
  assign in_tready = !st_valid_r || push_ready;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_take) begin
      st_valid_nxt = 1'b1;
    end else if (push_ready) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  // Capture the job: radix from the selector, value as is
  always_ff @(posedge clk) begin
    if (in_take) begin
      st_job_r.hex   <= in_tuser;
      st_job_r.value <= in_tdata;
    end
  end

  assign push_valid = st_valid_r;
  assign push_job   = st_job_r;

endmodule

@@ rtl/n2a_queue.sv @@
// Short job queue between the front end and the conversion engine.
// Depends on n2a_pkg for the job type.
`timescale 1ns / 1ps

module n2a_queue import n2a_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/n2a_back.sv @@
// Conversion engine: splits the value into digits with reciprocal
// multiplies for decimal or a nibble shift for hex, then sends the characters
// most significant first through an output register. Depends on n2a_pkg.
`timescale 1ns / 1ps

module n2a_back import n2a_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_pop,
  input  job_t              job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [CHAR_W-1:0] out_tdata,   // [7:0] ascii_char
  output logic              out_tlast    // last_char
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_PFX0 = 5'b00100,
    S_PFX1 = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [VALUE_W-1:0]   work_r, work_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic                 hex_r, hex_nxt;
  logic [DIG_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic [DIGIT_W-1:0]   dig_r [MAX_DIGITS];
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   rem_full;
  logic [DIGIT_W-1:0]   rem;
  logic                 dig_we;
  logic                 out_free;

  // Quotient and remainder of the current dividend
  always_comb begin
    if (hex_r) begin
      quot = {{DIGIT_W{1'b0}}, work_r[VALUE_W-1:DIGIT_W]};
    end else begin
      quot = {{(VALUE_W-QUOT_W){1'b0}}, prod_r[PROD_W-1:RECIP_SHIFT]};
    end
    rem_full = work_r - (quot << 3) - (quot << 1);
    rem      = hex_r ? work_r[DIGIT_W-1:0] : rem_full[DIGIT_W-1:0];
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    prod_nxt      = prod_r;
    hex_nxt       = hex_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    job_pop       = 1'b0;
    dig_we        = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    // Drop the held beat once taken
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Take the next job and start its first multiply
        if (job_valid) begin
          job_pop   = 1'b1;
          work_nxt  = job.value;
          hex_nxt   = job.hex;
          prod_nxt  = PROD_W'(job.value) * PROD_W'(RECIP_10);
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        // Store one digit, least significant first
        dig_we   = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        work_nxt = quot;
        prod_nxt = PROD_W'(quot) * PROD_W'(RECIP_10);
        if (quot == '0) begin
          idx_nxt   = cnt_r;
          state_nxt = hex_r ? S_PFX0 : S_EMIT;
        end
      end
      S_PFX0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = DIGIT_BASE;
          out_last_nxt  = 1'b0;
          state_nxt     = S_PFX1;
        end
      end
      S_PFX1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = CHAR_X;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        // Send digits most significant first, flag the final one
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = digit_to_ascii(dig_r[idx_r]);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    prod_r     <= prod_nxt;
    hex_r      <= hex_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit buffer
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[cnt_r] <= rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/number_to_ascii_formatter.sv @@
// Top level of the number-to-ASCII formatter: front end, job queue and
// conversion engine. Depends on n2a_pkg, n2a_front, n2a_queue, n2a_back.
`timescale 1ns / 1ps

// Each input beat carries a 32-bit unsigned value on in_tdata and a radix
// select on in_tuser (0 decimal, 1 hex with a "0x" prefix). The block sends
// the text one character per output beat, most significant digit first,
// no leading zeros (zero gives "0"), hex digits in lower case, with
// out_tlast on the final character. For each value the engine loads the
// job, splits the digits one per cycle (a reciprocal multiply for decimal,
// a nibble shift for hex), then sends the "0x" prefix in hex mode and the
// digits, one character per cycle from the output register while out_tready
// does not stall it. Input beats are taken into a stage register and a
// QUEUE_DEPTH-entry queue while the engine is busy.

module number_to_ascii_formatter import n2a_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic               in_tuser,   // [0] action
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [CHAR_W-1:0]  out_tdata,  // [7:0] ascii_char
  output logic               out_tlast   // last_char
);

  logic push_valid, push_ready;
  job_t push_job;
  logic job_valid, job_pop;
  job_t job;

  n2a_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  n2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop        (job_pop),
    .pop_job    (job)
  );

  n2a_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job_pop    (job_pop),
    .job        (job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/n2a_checker.sv @@
// Port-level checks for the number-to-ASCII formatter, bound to the top
// level. Depends on the top level's port list only.
`timescale 1ns / 1ps

module n2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // No output beat straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Keep the input handshake defined while a beat is offered
  a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tready))
    else $error("input ready unknown while a beat is offered");

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // Only digits, lower-case hex letters and the prefix letter appear
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                    (out_tdata >= 8'h61 && out_tdata <= 8'h66) ||
                    out_tdata == 8'h78))
    else $error("character outside the digit set");

  // The prefix letter is never the final character
  a_x_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == 8'h78 |-> !out_tlast)
    else $error("prefix marked as last character");

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ verif/n2a_text_checker.sv @@
// Scoreboard for the number-to-ASCII formatter: watches both streams, predicts
// the text of every accepted value and compares each output beat in order.
// Depends on n2a_pkg for the port widths.
`timescale 1ns / 1ps

module n2a_text_checker import n2a_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic               in_tuser,   // [0] action
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [CHAR_W-1:0]  out_tdata,  // [7:0] ascii_char
  input  logic               out_tlast,  // last_char
  output int                 chars_pending,
  output int                 mismatches
);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic              RADIX_SEL_HEX = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t expected_text[$];

  initial begin
    chars_pending = 0;
    mismatches    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [3:0] d);
    logic [CHAR_W-1:0] d8;
    d8 = {4'h0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end
    return CH_ALPHA + d8 - 8'd10;
  endfunction

  // Split the value into digits, least significant first, then queue the
  // characters most significant first with the prefix ahead in hex mode
  task automatic predict_text(input logic hex, input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rest;
    logic [3:0]         digs[MAX_DIGITS];
    int                 nd;
    text_char_t         c;
    rest = value;
    nd   = 0;
    do begin
      if (hex == RADIX_SEL_HEX) begin
        digs[nd] = rest[3:0];
        rest     = rest >> 4;
      end else begin
        digs[nd] = 4'(rest % 10);
        rest     = rest / 10;
      end
      nd++;
    end while (rest != 0);
    if (hex == RADIX_SEL_HEX) begin
      c.ch = CH_ZERO; c.last = 1'b0; expected_text.push_back(c);
      c.ch = CH_X;    c.last = 1'b0; expected_text.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch   = glyph_of(digs[k]);
      c.last = (k == 0);
      expected_text.push_back(c);
    end
  endtask

  // Queue predictions for accepted values, then match each output beat
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tuser, in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char=%h last=%b", out_tdata, out_tlast));
        end else begin
          want = expected_text.pop_front();
          if (out_tdata !== want.ch) begin
            report_mismatch($sformatf("ascii_char got %h want %h", out_tdata, want.ch));
          end
          if (out_tlast !== want.last) begin
            report_mismatch($sformatf("last_char got %b want %b (char %h)",
                                      out_tlast, want.last, want.ch));
          end
        end
      end
    end
    chars_pending = expected_text.size();
  end

endmodule

@@ verif/tb_number_to_ascii_formatter.sv @@
// Testbench top for the number-to-ASCII formatter: clock, reset, value
// stimulus under several idle and stall mixes, watchdog and verdict.
// Depends on n2a_pkg, number_to_ascii_formatter and n2a_text_checker.
`timescale 1ns / 1ps

module tb_number_to_ascii_formatter;
  import n2a_pkg::*;

  localparam int  WATCHDOG_LIMIT  = 2000;
  localparam int  RANDOM_PER_MIX  = 105;
  localparam int  TAIL_CYCLES     = 40;
  localparam logic SEL_DEC = 1'b0;
  localparam logic SEL_HEX = 1'b1;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata;   // [31:0] value
  logic               in_tuser;   // [0] action
  logic               out_tvalid;
  logic               out_tready;
  logic [CHAR_W-1:0]  out_tdata;  // [7:0] ascii_char
  logic               out_tlast;  // last_char

  int chars_pending;
  int mismatches;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  number_to_ascii_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  n2a_text_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .chars_pending (chars_pending),
    .mismatches    (mismatches)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= stall_pct);
  end

  // End the run if neither stream moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one value, idling first at the current rate; valid stays high
  // across back-to-back beats
  task automatic send_value(input logic sel, input logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = value;
    in_tuser  = sel;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the input until all queued text has drained
  task automatic drain_text();
    in_tvalid = 1'b0;
    while (chars_pending != 0) @(negedge clk);
  endtask

  // Mostly short numbers, with full-width values and radix boundaries mixed in
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    int                 k;
    p = 32'd1;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom >> $urandom_range(4, 31);
      4:          return $urandom;
      5: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      6:       return (32'd1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    int idle_mix[4];
    int stall_mix[4];
    idle_mix  = '{0, 58, 0, 36};
    stall_mix = '{0, 0, 58, 36};
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = SEL_DEC;
    out_tready   = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero, full range, digit-count and radix boundaries
    send_value(SEL_DEC, 32'd0);
    send_value(SEL_HEX, 32'd0);
    send_value(SEL_DEC, 32'hFFFF_FFFF);
    send_value(SEL_HEX, 32'hFFFF_FFFF);
    send_value(SEL_DEC, 32'd1);
    send_value(SEL_HEX, 32'd1);
    send_value(SEL_DEC, 32'd9);
    send_value(SEL_DEC, 32'd10);
    send_value(SEL_DEC, 32'd99);
    send_value(SEL_DEC, 32'd100);
    send_value(SEL_DEC, 32'd999_999_999);
    send_value(SEL_DEC, 32'd1_000_000_000);
    send_value(SEL_DEC, 32'h8000_0000);
    send_value(SEL_HEX, 32'h8000_0000);
    send_value(SEL_HEX, 32'h0000_000F);
    send_value(SEL_HEX, 32'h0000_0010);
    send_value(SEL_HEX, 32'h0FFF_FFFF);
    send_value(SEL_HEX, 32'h1000_0000);
    send_value(SEL_HEX, 32'hABCD_EF01);
    send_value(SEL_HEX, 32'h1234_5678);
    send_value(SEL_DEC, 32'h5555_5555);
    send_value(SEL_HEX, 32'hAAAA_AAAA);
    drain_text();

    // Random values under each idle and stall mix, draining between mixes
    for (int m = 0; m < 4; m++) begin
      idle_pct  = idle_mix[m];
      stall_pct = stall_mix[m];
      for (int i = 0; i < RANDOM_PER_MIX; i++) begin
        send_value(logic'($urandom_range(0, 1)), pick_value());
      end
      drain_text();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/n2a_pkg.sv
rtl/n2a_front.sv
rtl/n2a_queue.sv
rtl/n2a_back.sv
rtl/number_to_ascii_formatter.sv
rtl/n2a_checker.sv
verif/n2a_text_checker.sv
verif/tb_number_to_ascii_formatter.sv
